// ===== design/md5_pkg.sv =====
// Package for the MD5 digest block: types, constants and round tables.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;
	localparam logic [5:0]  LAST_POS = 6'h3f;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FIN,
		ST_EMIT
	} md5_state_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  addr;
		logic [31:0] data;
	} md5_wr_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] word;
		logic [1:0]  idx;
		logic        last;
	} md5_dig_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word used by round i
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0:    g = i[3:0];
			2'd1:    g = i[3:0] * 4'd5 + 4'd1;
			2'd2:    g = i[3:0] * 4'd3 + 4'd5;
			default: g = i[3:0] * 4'd7;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

endpackage
`default_nettype wire

// ===== design/md5_wmem.sv =====
// Message block memory: 16 words of 32 bits, one write port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module md5_wmem (
	input  wire logic             clk,
	input  wire md5_pkg::md5_wr_t wr,
	input  wire logic [3:0]       raddr,
	output logic [31:0]           rdata
);
	import md5_pkg::*;

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/md5_core.sv =====
// MD5 control and round datapath: byte packing, padding, 64 rounds, digest readout.
`timescale 1ns / 1ps
`default_nettype none
module md5_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output md5_pkg::md5_wr_t       wr,
	output logic [3:0]             raddr,
	input  wire logic [31:0]       rdata,
	output md5_pkg::md5_dig_t      dig,
	input  wire logic              dig_take
);
	import md5_pkg::*;

	md5_state_t state_q, state_d;

	logic [3:0][31:0] cv_q;
	logic [31:0]      a_q, b_q, c_q, d_q;
	logic [60:0]      cnt_q;
	logic [5:0]       fill_q;
	logic [5:0]       rnd_q;
	logic [23:0]      asm_q;
	logic [1:0]       idx_q;
	logic             pad_q, first_q, len_q, final_q;

	logic        ins_en;
	logic [7:0]  ins_byte;
	logic [7:0]  pad_byte;
	logic [63:0] len_bits;
	logic        blk_full;
	logic [31:0] f;
	logic [31:0] t;

	assign len_bits = {cnt_q, 3'b000};
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_q && fill_q >= LEN_POS) begin
			pad_byte = len_bits[{fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign ins_en   = (state_q == ST_IDLE && in_valid) || state_q == ST_PAD;
	assign ins_byte = (state_q == ST_IDLE) ? data_byte : pad_byte;
	assign blk_full = ins_en && fill_q == LAST_POS;

	assign wr.en   = ins_en && fill_q[1:0] == 2'd3;
	assign wr.addr = fill_q[5:2];
	assign wr.data = {ins_byte, asm_q};

	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
	end
	assign t = a_q + f + md5_k(rnd_q) + rdata;

	always_comb begin
		state_d = state_q;
		raddr   = 4'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (fill_q == LAST_POS) begin
						state_d = ST_LOAD;
					end else if (last_byte) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_POS) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				raddr   = md5_g(6'd0);
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				raddr = md5_g(rnd_q + 6'd1);
				if (rnd_q == LAST_POS) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (final_q) begin
					state_d = ST_EMIT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (dig_take && idx_q == 2'd3) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign dig.valid = (state_q == ST_EMIT);
	assign dig.word  = cv_q[idx_q];
	assign dig.idx   = idx_q;
	assign dig.last  = (idx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q    <= {INIT_D, INIT_C, INIT_B, INIT_A};
			cnt_q   <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			final_q <= 1'b0;
		end else begin
			if (ins_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == ST_IDLE && in_valid) begin
				cnt_q <= cnt_q + 61'd1;
				if (last_byte) begin
					pad_q   <= 1'b1;
					first_q <= 1'b1;
					len_q   <= 1'b0;
				end
			end
			if (state_q == ST_PAD) begin
				first_q <= 1'b0;
				if (blk_full) begin
					len_q <= 1'b1;
				end else if (first_q) begin
					len_q <= (fill_q < LEN_POS);
				end
			end
			if (blk_full) begin
				final_q <= (state_q == ST_PAD) && len_q && !first_q;
			end
			if (state_q == ST_LOAD) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_FIN) begin
				cv_q[0] <= cv_q[0] + a_q;
				cv_q[1] <= cv_q[1] + b_q;
				cv_q[2] <= cv_q[2] + c_q;
				cv_q[3] <= cv_q[3] + d_q;
			end
			if (state_q == ST_EMIT && dig_take) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					cv_q    <= {INIT_D, INIT_C, INIT_B, INIT_A};
					cnt_q   <= '0;
					pad_q   <= 1'b0;
					len_q   <= 1'b0;
					final_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en && fill_q[1:0] != 2'd3) begin
			asm_q[{fill_q[1:0], 3'b000} +: 8] <= ins_byte;
		end
		if (state_q == ST_LOAD) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
		end else if (state_q == ST_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + md5_rotl(t, md5_rot(rnd_q));
		end
	end

endmodule
`default_nettype wire

// ===== design/md5_message_digest.sv =====
// MD5 digest block: top level with block memory, round core and output register.
// Usage:
//   Message bytes enter on data_byte with in_valid/in_ready; last_byte marks
//   the final byte of a message. For each message four words leave on
//   digest_word/word_index/last_word with out_valid/out_ready, A first,
//   last_word set on D.
//   Ordinary bytes are accepted one per cycle while in_ready is high. The 64th
//   byte of a block starts a compression (a read-prime step, 64 rounds at
//   one round per cycle reading the 16-word block memory, an add-back step),
//   during which in_ready is low. A final byte is followed by padding written
//   one byte per cycle up to the end of the block, one or two compressions,
//   and the four digest words being handed to the output register; the input
//   then opens again.
//   The output register takes a word when it is empty or being drained, so a
//   stall at out_ready holds the digest readout but never loses a word.
//   Reset loads the initial chaining values and clears the bit count and the
//   fill position; the block memory is not cleared, every entry is written
//   before it is read.
`timescale 1ns / 1ps
`default_nettype none
module md5_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word,
	output logic             out_valid,
	input  wire logic        out_ready
);
	import md5_pkg::*;

	md5_wr_t     wr;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	md5_dig_t    dig;
	logic        dig_take;

	md5_wmem u_wmem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.wr        (wr),
		.raddr     (raddr),
		.rdata     (rdata),
		.dig       (dig),
		.dig_take  (dig_take)
	);

	assign dig_take = dig.valid && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (dig_take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_take) begin
			digest_word <= dig.word;
			word_index  <= dig.idx;
			last_word   <= dig.last;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !dig.valid)
		else $error("input open while digest readout active");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		dig_take && dig.last |=> in_ready)
		else $error("input not reopened after final digest word");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 2'd3)))
		else $error("last_word flag does not match word_index");

endmodule
`default_nettype wire
